/* rtl/assert_macros.svh */
// assertion macros of the edge blend mask block
// no dependencies; included by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/pbm_pkg.sv */
// shared constants, codes and types of the projector edge blend mask block
// no dependencies; imported by every module of the block but pbm_ram
package pbm_pkg;

  localparam int MAX_BORDER = 256;
  localparam int MAX_RES    = 4096;

  localparam int PIX_W      = $clog2(MAX_RES);        // pixel coordinate
  localparam int RES_W      = $clog2(MAX_RES) + 1;    // resolution register
  localparam int RAMP_AW    = $clog2(MAX_BORDER);     // ramp table address
  localparam int BORDER_W   = $clog2(MAX_BORDER) + 1; // border register
  localparam int TILE_W     = 4;
  localparam int TILES_W    = 5;
  localparam int IDX_W      = 8;
  localparam int RAMP_W     = 16;
  localparam int REQ_W      = 2;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RES_W;

  // factor in q1.16 so that a missing factor can stand as exactly 1.0
  localparam int FACTOR_W   = RAMP_W + 1;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << RAMP_W;
  localparam int NUM_FACTORS = 4;

  // product widths through the multiplier stages
  localparam int PAIR_W     = 2 * FACTOR_W;            // two factors
  localparam int PART_W     = PAIR_W + FACTOR_W;       // pair times half pair
  localparam int FULL_W     = 2 * PAIR_W;              // sum of partials
  localparam int SCALE_SHIFT = NUM_FACTORS * RAMP_W;   // q0.64 binary point
  localparam int P_W        = SCALE_SHIFT + 1;         // product is at most 1.0
  localparam int SCALED_W   = P_W + MASK_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_PIXEL  = 2'd0,
    REQ_LOAD_X = 2'd1,
    REQ_LOAD_Y = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_COL = 3'd0,
    CFG_TILE_ROW = 3'd1,
    CFG_TILES_X  = 3'd2,
    CFG_TILES_Y  = 3'd3,
    CFG_WIDTH    = 3'd4,
    CFG_HEIGHT   = 3'd5,
    CFG_BORDER_X = 3'd6,
    CFG_BORDER_Y = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [TILE_W-1:0]   tile_col;
    logic [TILE_W-1:0]   tile_row;
    logic [TILES_W-1:0]  tiles_x;
    logic [TILES_W-1:0]  tiles_y;
    logic [RES_W-1:0]    width;
    logic [RES_W-1:0]    height;
    logic [BORDER_W-1:0] border_x;
    logic [BORDER_W-1:0] border_y;
  } cfg_t;

  typedef logic [NUM_FACTORS-1:0][FACTOR_W-1:0] factors_t;

endpackage

/* rtl/projector_edge_blend_mask.sv */
// Edge blend mask generator for one tile of a grid of overlapping projectors.
// A stream of requests comes in on the s_ side; tuser says what each request
// is: a pixel query, or a load of one entry of the horizontal or vertical ramp
// table (unsigned q0.16 factors). For a query the block multiplies the ramp
// factors that apply to the pixel (left, right with mirrored index, and the
// two vertical ones, chosen by the tile's place in the grid) and returns
// floor(255 * product) on the m_ side; with no factor the answer is 255. Loads
// return nothing and the product is exact. One request is taken every cycle
// when not stalled. A query passes the request, ram output, pair, partial,
// product and output registers. Each ramp table is one ram with one write port
// and two read ports, so both of a table's lookups happen in the same cycle.
// The ramp tables are not cleared at reset: every entry that a query reaches
// must have been loaded first. The user writes configuration registers through
// the cfg_ channel while no request is in flight; the block does not check it.
// depends on pbm_pkg, pbm_cfg, pbm_front, pbm_prod, pbm_ram, assert_macros.svh
`include "assert_macros.svh"

module projector_edge_blend_mask (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [47:0]                    s_tdata,   // pix_x, pix_y, ramp_index, ramp_value
  input  logic [pbm_pkg::REQ_W-1:0]      s_tuser,   // req_type
  // mask stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pbm_pkg::MASK_W-1:0]     m_tdata,   // mask_value
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pbm_pkg::*;

  cfg_t     cfg;
  factors_t factors;
  logic     f_valid, p_ready;

  // register file
  pbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // request register, factor decode, table writes and lookups
  pbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (s_tuser),
    .in_x       (s_tdata[PIX_W-1:0]),
    .in_y       (s_tdata[2*PIX_W-1:PIX_W]),
    .in_idx     (s_tdata[2*PIX_W+IDX_W-1:2*PIX_W]),
    .in_val     (s_tdata[2*PIX_W+IDX_W+RAMP_W-1:2*PIX_W+IDX_W]),
    .out_valid  (f_valid),
    .out_ready  (p_ready),
    .out_factor (factors)
  );

  // four-factor product, scaling by 255 and the output register
  pbm_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (p_ready),
    .in_factor (factors),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_mask  (m_tdata)
  );

  // requests are refused only when every stage is full behind a stalled result
  `ASSERT_IMPLY(a_full_stall, clk, rst, !s_tready, m_tvalid && !m_tready)
  // a looked-up query waits in place while the product pipe is full
  `ASSERT_NEXT(a_front_hold, clk, rst, f_valid && !p_ready, f_valid)

endmodule

/* rtl/pbm_ram.sv */
// generic single write, dual read ram with registered read data
// no dependencies
module pbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/pbm_cfg.sv */
// configuration register file of the edge blend mask block
// depends on pbm_pkg
module pbm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbm_pkg::CFG_DATA_W-1:0] cfg_data,
  output pbm_pkg::cfg_t                  cfg
);
  import pbm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_col <= '0;
      cfg.tile_row <= '0;
      cfg.tiles_x  <= TILES_W'(1);
      cfg.tiles_y  <= TILES_W'(1);
      cfg.width    <= RES_W'(1024);
      cfg.height   <= RES_W'(768);
      cfg.border_x <= '0;
      cfg.border_y <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TILE_COL: cfg.tile_col <= cfg_data[TILE_W-1:0];
        CFG_TILE_ROW: cfg.tile_row <= cfg_data[TILE_W-1:0];
        CFG_TILES_X:  cfg.tiles_x  <= cfg_data[TILES_W-1:0];
        CFG_TILES_Y:  cfg.tiles_y  <= cfg_data[TILES_W-1:0];
        CFG_WIDTH:    cfg.width    <= cfg_data[RES_W-1:0];
        CFG_HEIGHT:   cfg.height   <= cfg_data[RES_W-1:0];
        CFG_BORDER_X: cfg.border_x <= cfg_data[BORDER_W-1:0];
        CFG_BORDER_Y: cfg.border_y <= cfg_data[BORDER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/pbm_front.sv */
// input stage, factor decode and ramp table lookup of the edge blend mask block
// depends on pbm_pkg and pbm_ram
module pbm_front (
  input  logic                       clk,
  input  logic                       rst,
  input  pbm_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pbm_pkg::REQ_W-1:0]  in_req,
  input  logic [pbm_pkg::PIX_W-1:0]  in_x,
  input  logic [pbm_pkg::PIX_W-1:0]  in_y,
  input  logic [pbm_pkg::IDX_W-1:0]  in_idx,
  input  logic [pbm_pkg::RAMP_W-1:0] in_val,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pbm_pkg::factors_t          out_factor
);
  import pbm_pkg::*;

  // stage 1: request register
  logic              v1;
  logic [REQ_W-1:0]  req1;
  logic [PIX_W-1:0]  x1;
  logic [PIX_W-1:0]  y1;
  logic [IDX_W-1:0]  idx1;
  logic [RAMP_W-1:0] val1;

  // stage 2: factor enables, table data sits in the ram output registers
  logic                   v2;
  logic [NUM_FACTORS-1:0] use2;

  logic s2_free;
  assign s2_free  = !v2 || out_ready;
  assign in_ready = !v1 || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      req1 <= in_req;
      x1   <= in_x;
      y1   <= in_y;
      idx1 <= in_idx;
      val1 <= in_val;
    end
  end

  // border clamp to the table length
  logic [BORDER_W-1:0] bx, by;
  assign bx = (cfg.border_x > BORDER_W'(MAX_BORDER)) ? BORDER_W'(MAX_BORDER) : cfg.border_x;
  assign by = (cfg.border_y > BORDER_W'(MAX_BORDER)) ? BORDER_W'(MAX_BORDER) : cfg.border_y;

  logic [RES_W-1:0] xe, ye, x_far, y_far, x_mirror, y_mirror;
  assign xe       = RES_W'(x1);
  assign ye       = RES_W'(y1);
  assign x_far    = xe + RES_W'(bx);
  assign y_far    = ye + RES_W'(by);
  assign x_mirror = cfg.width - RES_W'(1) - xe;
  assign y_mirror = cfg.height - RES_W'(1) - ye;

  logic has_left, has_right, has_low, has_high;
  assign has_left  = (cfg.tile_col != '0) && (xe < RES_W'(bx));
  assign has_right = ((TILES_W'(cfg.tile_col) + TILES_W'(1)) < cfg.tiles_x)
                     && (xe < cfg.width) && (x_far >= cfg.width);
  assign has_low   = ((TILES_W'(cfg.tile_row) + TILES_W'(1)) < cfg.tiles_y)
                     && (ye < RES_W'(by));
  assign has_high  = (cfg.tile_row != '0) && (ye < cfg.height) && (y_far >= cfg.height);

  logic is_load_x, is_load_y, idx_ok, leave1;
  assign leave1    = v1 && s2_free;
  assign idx_ok    = (BORDER_W'(idx1) < BORDER_W'(MAX_BORDER));
  assign is_load_x = (req1 == REQ_LOAD_X);
  assign is_load_y = (req1 == REQ_LOAD_Y);

  logic [RAMP_W-1:0] rx_a, rx_b, ry_a, ry_b;

  pbm_ram #(.WIDTH(RAMP_W), .DEPTH(MAX_BORDER)) u_ramp_x (
    .clk     (clk),
    .we      (leave1 && is_load_x && idx_ok),
    .waddr   (idx1[RAMP_AW-1:0]),
    .wdata   (val1),
    .re      (s2_free),
    .raddr_a (x1[RAMP_AW-1:0]),
    .raddr_b (x_mirror[RAMP_AW-1:0]),
    .rdata_a (rx_a),
    .rdata_b (rx_b)
  );

  pbm_ram #(.WIDTH(RAMP_W), .DEPTH(MAX_BORDER)) u_ramp_y (
    .clk     (clk),
    .we      (leave1 && is_load_y && idx_ok),
    .waddr   (idx1[RAMP_AW-1:0]),
    .wdata   (val1),
    .re      (s2_free),
    .raddr_a (y1[RAMP_AW-1:0]),
    .raddr_b (y_mirror[RAMP_AW-1:0]),
    .rdata_a (ry_a),
    .rdata_b (ry_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_free) begin
      v2 <= v1 && (req1 == REQ_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      use2 <= {has_high, has_low, has_right, has_left};
    end
  end

  // a factor that does not apply stands as 1.0
  assign out_valid     = v2;
  assign out_factor[0] = use2[0] ? FACTOR_W'(rx_a) : FACTOR_ONE;
  assign out_factor[1] = use2[1] ? FACTOR_W'(rx_b) : FACTOR_ONE;
  assign out_factor[2] = use2[2] ? FACTOR_W'(ry_a) : FACTOR_ONE;
  assign out_factor[3] = use2[3] ? FACTOR_W'(ry_b) : FACTOR_ONE;

endmodule

/* rtl/pbm_prod.sv */
// multiplier pipeline and output register of the edge blend mask block
// depends on pbm_pkg
module pbm_prod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pbm_pkg::factors_t          in_factor,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pbm_pkg::MASK_W-1:0] out_mask
);
  import pbm_pkg::*;

  logic              va, vb, vc;
  logic [PAIR_W-1:0] m01, m23;
  logic [PART_W-1:0] part_lo, part_hi;
  logic [P_W-1:0]    prod;

  logic free_a, free_b, free_c, free_d;
  assign free_d   = !out_valid || out_ready;
  assign free_c   = !vc || free_d;
  assign free_b   = !vb || free_c;
  assign free_a   = !va || free_b;
  assign in_ready = free_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free_a) begin
        va <= in_valid;
      end
      if (free_b) begin
        vb <= va;
      end
      if (free_c) begin
        vc <= vb;
      end
      if (free_d) begin
        out_valid <= vc;
      end
    end
  end

  logic [FULL_W-1:0]   sum_full;
  logic [SCALED_W-1:0] scaled;
  assign sum_full = {part_hi, {FACTOR_W{1'b0}}} + FULL_W'(part_lo);
  // times 255 as times 256 minus one
  assign scaled   = {prod, {MASK_W{1'b0}}} - SCALED_W'(prod);

  always_ff @(posedge clk) begin
    // pairs of factors
    if (free_a) begin
      m01 <= PAIR_W'(in_factor[0]) * PAIR_W'(in_factor[1]);
      m23 <= PAIR_W'(in_factor[2]) * PAIR_W'(in_factor[3]);
    end
    // second pair split in halves to keep each multiplier narrow
    if (free_b) begin
      part_lo <= PART_W'(m01) * PART_W'(m23[FACTOR_W-1:0]);
      part_hi <= PART_W'(m01) * PART_W'(m23[PAIR_W-1:FACTOR_W]);
    end
    if (free_c) begin
      prod <= sum_full[P_W-1:0];
    end
    if (free_d) begin
      out_mask <= scaled[SCALE_SHIFT +: MASK_W];
    end
  end

endmodule
